/* hw/rtl/bcpa_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package bcpa_pkg;

    localparam int PAGE_TOTAL = 4096;
    localparam int PAGE_W     = 12;
    localparam int CNT_W      = 13;
    localparam int WIDE_W     = 14;
    localparam int WORD_W     = 32;
    localparam int BIT_W      = 5;
    localparam int NUM_WORDS  = PAGE_TOTAL / WORD_W;
    localparam int WADDR_W    = PAGE_W - BIT_W;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_SPACE = 2'd1;
    localparam logic [1:0] ST_BAD      = 2'd2;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    localparam logic [CNT_W-1:0] GRANULE_RESET = 13'd8;

    typedef struct packed {
        logic                 rd_en;
        logic [WADDR_W-1:0]   rd_addr;
        logic                 wr_en;
        logic [WADDR_W-1:0]   wr_addr;
        logic [WORD_W-1:0]    wr_data;
    } mem_req_t;

    typedef struct packed {
        logic                 start;
        logic [WIDE_W-1:0]    want;
        logic [CNT_W-1:0]     granule;
    } fit_req_t;

    typedef struct packed {
        logic                 done;
        logic [CNT_W-1:0]     size;
    } fit_rsp_t;

endpackage
`default_nettype wire

/* hw/rtl/bcpa_bitmap.sv */
`timescale 1ns / 1ps
`default_nettype none
module bcpa_bitmap
    import bcpa_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire mem_req_t          req,
    output logic [WORD_W-1:0]      rd_data
);

    // Words never written since reset read as their reset contents.
    logic [WORD_W-1:0]    mem [NUM_WORDS];
    logic [NUM_WORDS-1:0] valid_reg;
    logic [WORD_W-1:0]    rd_data_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en) begin
            if (valid_reg[req.rd_addr]) begin
                rd_data_reg <= mem[req.rd_addr];
            end else if (req.rd_addr == '0) begin
                rd_data_reg <= {{(WORD_W-1){1'b0}}, 1'b1};
            end else begin
                rd_data_reg <= '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (req.wr_en) begin
            valid_reg[req.wr_addr] <= 1'b1;
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

/* hw/rtl/bcpa_fit.sv */
`timescale 1ns / 1ps
`default_nettype none
module bcpa_fit
    import bcpa_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire fit_req_t  req,
    output fit_rsp_t       rsp
);

    // Rounds up to a granule multiple, then caps at the largest multiple within
    // the page count. Two restoring divisions and one multiply.
    typedef enum logic [1:0] {IDLE, DIV1, DIV2, MUL} state_t;

    state_t            state_reg, state_next;
    logic [WIDE_W-1:0] num_reg, num_next;
    logic [WIDE_W-1:0] rem_reg, rem_next;
    logic [WIDE_W-1:0] q_reg, q_next;
    logic [WIDE_W-1:0] q1_reg, q1_next;
    logic [3:0]        cnt_reg, cnt_next;
    logic [CNT_W-1:0]  g_reg, g_next;
    logic [CNT_W-1:0]  size_reg, size_next;
    logic              done_reg, done_next;

    logic [WIDE_W-1:0] base;
    logic [WIDE_W-1:0] rem_sh;
    logic              qbit;
    logic [WIDE_W-1:0] q_new;
    logic [WIDE_W+CNT_W-1:0] prod;

    always_comb begin
        base   = (req.want < {1'b0, req.granule}) ? {1'b0, req.granule} : req.want;
        rem_sh = {rem_reg[WIDE_W-2:0], num_reg[WIDE_W-1]};
        qbit   = rem_sh >= {1'b0, g_reg};
        q_new  = {q_reg[WIDE_W-2:0], qbit};
        prod   = q_reg * g_reg;

        state_next = state_reg;
        num_next   = num_reg;
        rem_next   = rem_reg;
        q_next     = q_reg;
        q1_next    = q1_reg;
        cnt_next   = cnt_reg;
        g_next     = g_reg;
        size_next  = size_reg;
        done_next  = 1'b0;

        case (state_reg)
            IDLE: begin
                if (req.start) begin
                    g_next     = req.granule;
                    num_next   = base + {1'b0, req.granule} - 14'd1;
                    rem_next   = '0;
                    q_next     = '0;
                    cnt_next   = '0;
                    state_next = DIV1;
                end
            end
            DIV1, DIV2: begin
                rem_next = qbit ? (rem_sh - {1'b0, g_reg}) : rem_sh;
                num_next = {num_reg[WIDE_W-2:0], 1'b0};
                q_next   = q_new;
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'(WIDE_W - 1)) begin
                    cnt_next = '0;
                    rem_next = '0;
                    if (state_reg == DIV1) begin
                        q1_next    = q_new;
                        q_next     = '0;
                        num_next   = WIDE_W'(PAGE_TOTAL);
                        state_next = DIV2;
                    end else begin
                        q_next     = (q1_reg < q_new) ? q1_reg : q_new;
                        state_next = MUL;
                    end
                end
            end
            MUL: begin
                size_next  = prod[CNT_W-1:0];
                done_next  = 1'b1;
                state_next = IDLE;
            end
            default: state_next = IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
        num_reg  <= num_next;
        rem_reg  <= rem_next;
        q_reg    <= q_next;
        q1_reg   <= q1_next;
        cnt_reg  <= cnt_next;
        g_reg    <= g_next;
        size_reg <= size_next;
    end

    assign rsp.done = done_reg;
    assign rsp.size = size_reg;

endmodule
`default_nettype wire

/* hw/rtl/bitmap_contiguous_page_allocator.sv */
`timescale 1ns / 1ps
`default_nettype none
// First-fit allocator of contiguous page runs over a 4096-page usage bitmap.
// A request beat carries the kind in s_tuser and the start page and run length
// in s_tdata; each request gives exactly one result beat with the granted
// page, a status (ok, no space, bad request) and the pool size afterwards.
// The bitmap lives in a 128 x 32 bit synchronous memory and is walked one
// page per cycle through a one-word cache, pausing to fetch a word from the
// memory whenever the page's word is not cached. Freeing a run checks it,
// clears it and then scans onward from its start, and the pool is resized
// by the division unit when a request grows or shrinks it. One request is
// handled at a time, and the next request beat is taken while a result beat
// still waits on m_tready. The memory needs no clearing pass after reset.
// The granule register may be written only while no request is in flight.
module bitmap_contiguous_page_allocator
    import bcpa_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [12:0] cfg_wr_data,   // size_granule
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,       // start_page[11:0], run_length[24:12]
    input  wire logic [0:0]  s_tuser,       // kind[0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata        // granted_page[11:0], status[13:12],
                                            // pool_pages[26:14]
);

    typedef enum logic [3:0] {
        IDLE, FETCH, A_START, A_SKIP, A_CHK, A_FITW, A_SCAN, A_SET, A_HINT,
        F_START, F_CHK, F_CLR, F_SCANP, F_FITW, DONE
    } state_t;

    state_t             state_reg, state_next;
    state_t             ret_reg, ret_next;
    logic               kind_reg, kind_next;
    logic [CNT_W-1:0]   start_reg, start_next;
    logic [CNT_W-1:0]   run_reg, run_next;
    logic [CNT_W-1:0]   pool_reg, pool_next;
    logic [CNT_W-1:0]   hint_reg, hint_next;
    logic [CNT_W-1:0]   gran_reg;
    logic [CNT_W-1:0]   s_reg, s_next;
    logic [CNT_W-1:0]   tent_reg, tent_next;
    logic [CNT_W-1:0]   i_reg, i_next;
    logic [CNT_W-1:0]   p_reg, p_next;
    logic [PAGE_W-1:0]  res_page_reg, res_page_next;
    logic [1:0]         res_status_reg, res_status_next;
    logic               m_valid_reg, m_valid_next;
    logic [31:0]        m_data_reg, m_data_next;

    // One-word cache in front of the bitmap memory, kept coherent by
    // writing every update through to both.
    logic               cvalid_reg, cvalid_next;
    logic [WADDR_W-1:0] cidx_reg, cidx_next;
    logic [WORD_W-1:0]  cword_reg, cword_next;
    logic [WADDR_W-1:0] fidx_reg, fidx_next;

    mem_req_t           mreq;
    logic [WORD_W-1:0]  mrd;
    fit_req_t           freq;
    fit_rsp_t           frsp;

    logic [CNT_W-1:0]   gran_eff;
    logic [CNT_W-1:0]   addr;
    logic               hit;
    logic               cbit;
    logic [WIDE_W-1:0]  s_end;
    logic [WIDE_W-1:0]  f_end;
    logic [WORD_W-1:0]  wmask;

    bcpa_bitmap u_bitmap (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mreq),
        .rd_data (mrd)
    );

    bcpa_fit u_fit (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (freq),
        .rsp     (frsp)
    );

    assign s_tready = (state_reg == IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    always_comb begin
        if (gran_reg == '0) begin
            gran_eff = 13'd1;
        end else if (gran_reg > CNT_W'(PAGE_TOTAL)) begin
            gran_eff = CNT_W'(PAGE_TOTAL);
        end else begin
            gran_eff = gran_reg;
        end
    end

    always_comb begin
        case (state_reg)
            A_SKIP:          addr = s_reg;
            A_SCAN, A_SET:   addr = s_reg + i_reg;
            F_CHK, F_CLR:    addr = start_reg + i_reg;
            A_HINT, F_SCANP: addr = p_reg;
            default:         addr = s_reg;
        endcase
        hit   = cvalid_reg && (cidx_reg == addr[PAGE_W-1:BIT_W]);
        cbit  = cword_reg[addr[BIT_W-1:0]];
        wmask = {{(WORD_W-1){1'b0}}, 1'b1} << addr[BIT_W-1:0];
        s_end = {1'b0, s_reg} + {1'b0, run_reg};
        f_end = {1'b0, start_reg} + {1'b0, run_reg};
    end

    always_comb begin
        state_next      = state_reg;
        ret_next        = ret_reg;
        kind_next       = kind_reg;
        start_next      = start_reg;
        run_next        = run_reg;
        pool_next       = pool_reg;
        hint_next       = hint_reg;
        s_next          = s_reg;
        tent_next       = tent_reg;
        i_next          = i_reg;
        p_next          = p_reg;
        res_page_next   = res_page_reg;
        res_status_next = res_status_reg;
        cvalid_next     = cvalid_reg;
        cidx_next       = cidx_reg;
        cword_next      = cword_reg;
        fidx_next       = fidx_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_data_next     = m_data_reg;

        mreq.rd_en   = 1'b0;
        mreq.rd_addr = addr[PAGE_W-1:BIT_W];
        mreq.wr_en   = 1'b0;
        mreq.wr_addr = addr[PAGE_W-1:BIT_W];
        mreq.wr_data = cword_reg;

        freq.start   = 1'b0;
        freq.want    = (state_reg == F_SCANP) ? {1'b0, start_reg}
                                              : ({1'b0, tent_reg} + {1'b0, run_reg});
        freq.granule = gran_eff;

        case (state_reg)
            IDLE: begin
                if (s_tvalid) begin
                    kind_next  = s_tuser[0];
                    start_next = {1'b0, s_tdata[11:0]};
                    run_next   = s_tdata[24:12];
                    state_next = (s_tuser[0] == KIND_FREE) ? F_START : A_START;
                end
            end
            FETCH: begin
                cvalid_next = 1'b1;
                cidx_next   = fidx_reg;
                cword_next  = mrd;
                state_next  = ret_reg;
            end
            A_START: begin
                if (run_reg == '0) begin
                    res_page_next   = '0;
                    res_status_next = ST_BAD;
                    state_next      = DONE;
                end else begin
                    tent_next  = pool_reg;
                    s_next     = hint_reg;
                    state_next = A_SKIP;
                end
            end
            A_SKIP: begin
                if (s_reg < tent_reg) begin
                    if (!hit) begin
                        mreq.rd_en = 1'b1;
                        fidx_next  = addr[PAGE_W-1:BIT_W];
                        ret_next   = state_reg;
                        state_next = FETCH;
                    end else if (cbit) begin
                        s_next = s_reg + 13'd1;
                    end else begin
                        state_next = A_CHK;
                    end
                end else begin
                    state_next = A_CHK;
                end
            end
            A_CHK: begin
                i_next = '0;
                if (s_end > {1'b0, tent_reg}) begin
                    freq.start = 1'b1;
                    state_next = A_FITW;
                end else begin
                    state_next = A_SCAN;
                end
            end
            A_FITW: begin
                if (frsp.done) begin
                    if ({1'b0, frsp.size} < s_end) begin
                        res_page_next   = '0;
                        res_status_next = ST_NO_SPACE;
                        state_next      = DONE;
                    end else begin
                        tent_next  = frsp.size;
                        state_next = A_SCAN;
                    end
                end
            end
            A_SCAN: begin
                if (i_reg == run_reg) begin
                    i_next     = '0;
                    state_next = A_SET;
                end else if (!hit) begin
                    mreq.rd_en = 1'b1;
                    fidx_next  = addr[PAGE_W-1:BIT_W];
                    ret_next   = state_reg;
                    state_next = FETCH;
                end else if (cbit) begin
                    s_next     = s_reg + i_reg + 13'd1;
                    state_next = A_SKIP;
                end else begin
                    i_next = i_reg + 13'd1;
                end
            end
            A_SET: begin
                if (i_reg == run_reg) begin
                    pool_next = tent_reg;
                    if (s_reg == hint_reg) begin
                        p_next     = s_end[CNT_W-1:0];
                        state_next = A_HINT;
                    end else begin
                        res_page_next   = s_reg[PAGE_W-1:0];
                        res_status_next = ST_OK;
                        state_next      = DONE;
                    end
                end else if (!hit) begin
                    mreq.rd_en = 1'b1;
                    fidx_next  = addr[PAGE_W-1:BIT_W];
                    ret_next   = state_reg;
                    state_next = FETCH;
                end else begin
                    cword_next   = cword_reg | wmask;
                    mreq.wr_en   = 1'b1;
                    mreq.wr_data = cword_reg | wmask;
                    i_next       = i_reg + 13'd1;
                end
            end
            A_HINT: begin
                if ((p_reg < pool_reg) && !hit) begin
                    mreq.rd_en = 1'b1;
                    fidx_next  = addr[PAGE_W-1:BIT_W];
                    ret_next   = state_reg;
                    state_next = FETCH;
                end else if ((p_reg < pool_reg) && cbit) begin
                    p_next = p_reg + 13'd1;
                end else begin
                    hint_next       = p_reg;
                    res_page_next   = s_reg[PAGE_W-1:0];
                    res_status_next = ST_OK;
                    state_next      = DONE;
                end
            end
            F_START: begin
                i_next = '0;
                if ((run_reg == '0) || (start_reg == '0) || (f_end > {1'b0, pool_reg})) begin
                    res_page_next   = '0;
                    res_status_next = ST_BAD;
                    state_next      = DONE;
                end else begin
                    state_next = F_CHK;
                end
            end
            F_CHK: begin
                if (i_reg == run_reg) begin
                    i_next     = '0;
                    state_next = F_CLR;
                end else if (!hit) begin
                    mreq.rd_en = 1'b1;
                    fidx_next  = addr[PAGE_W-1:BIT_W];
                    ret_next   = state_reg;
                    state_next = FETCH;
                end else if (!cbit) begin
                    res_page_next   = '0;
                    res_status_next = ST_BAD;
                    state_next      = DONE;
                end else begin
                    i_next = i_reg + 13'd1;
                end
            end
            F_CLR: begin
                if (i_reg == run_reg) begin
                    if (start_reg < hint_reg) begin
                        hint_next = start_reg;
                    end
                    p_next     = start_reg;
                    state_next = F_SCANP;
                end else if (!hit) begin
                    mreq.rd_en = 1'b1;
                    fidx_next  = addr[PAGE_W-1:BIT_W];
                    ret_next   = state_reg;
                    state_next = FETCH;
                end else begin
                    cword_next   = cword_reg & ~wmask;
                    mreq.wr_en   = 1'b1;
                    mreq.wr_data = cword_reg & ~wmask;
                    i_next       = i_reg + 13'd1;
                end
            end
            F_SCANP: begin
                res_page_next   = '0;
                res_status_next = ST_OK;
                if (p_reg >= pool_reg) begin
                    freq.start = 1'b1;
                    state_next = F_FITW;
                end else if (!hit) begin
                    mreq.rd_en = 1'b1;
                    fidx_next  = addr[PAGE_W-1:BIT_W];
                    ret_next   = state_reg;
                    state_next = FETCH;
                end else if (!cbit) begin
                    p_next = p_reg + 13'd1;
                end else begin
                    state_next = DONE;
                end
            end
            F_FITW: begin
                if (frsp.done) begin
                    pool_next  = frsp.size;
                    state_next = DONE;
                end
            end
            DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {5'd0, pool_reg, res_status_reg, res_page_reg};
                    state_next   = IDLE;
                end
            end
            default: state_next = IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= IDLE;
            ret_reg     <= IDLE;
            gran_reg    <= GRANULE_RESET;
            pool_reg    <= GRANULE_RESET;
            hint_reg    <= 13'd1;
            cvalid_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            ret_reg     <= ret_next;
            pool_reg    <= pool_next;
            hint_reg    <= hint_next;
            cvalid_reg  <= cvalid_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                gran_reg <= cfg_wr_data;
            end
        end
        kind_reg       <= kind_next;
        start_reg      <= start_next;
        run_reg        <= run_next;
        s_reg          <= s_next;
        tent_reg       <= tent_next;
        i_reg          <= i_next;
        p_reg          <= p_next;
        res_page_reg   <= res_page_next;
        res_status_reg <= res_status_next;
        cidx_reg       <= cidx_next;
        cword_reg      <= cword_next;
        fidx_reg       <= fidx_next;
        m_data_reg     <= m_data_next;
    end

`ifndef NO_ASSERTIONS
    // The pool never falls to zero pages nor exceeds the bitmap.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (pool_reg != '0) && (pool_reg <= CNT_W'(PAGE_TOTAL)))
        else $error("pool size out of range");

    // Page zero is reserved, so the first-free hint never points at it.
    assert property (@(posedge aclk) disable iff (!aresetn) hint_reg != '0)
        else $error("free hint points at the reserved page");

    // An accepted request blocks further requests until its result is queued.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second request taken while one is in flight");

    // Only the three defined status codes ever leave the block.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[13:12] != 2'd3))
        else $error("undefined status code on result beat");
`endif

endmodule
`default_nettype wire
